// ===== rtl/ll1tp_pkg.sv =====
package ll1tp_pkg;

  localparam int unsigned STACK_DEPTH  = 16;
  localparam int unsigned RULE_MAX_LEN = 4;
  localparam int unsigned EXPAND_LIMIT = 4 * STACK_DEPTH;
  localparam int unsigned NUM_RULES    = 6;

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned BUD_W  = $clog2(EXPAND_LIMIT + 1);
  localparam int unsigned K_W    = (RULE_MAX_LEN > 1) ? $clog2(RULE_MAX_LEN) : 1;

  localparam int unsigned SYM_W   = 3;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned RULE_W  = 15;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned IDX_W   = 3;

  typedef logic [SYM_W-1:0] sym_t;

  localparam sym_t SYM_ZERO = 3'd0;
  localparam sym_t SYM_ONE  = 3'd1;
  localparam sym_t SYM_S    = 3'd2;
  localparam sym_t SYM_A    = 3'd3;
  localparam sym_t SYM_B    = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;

  typedef enum logic [STAT_W-1:0] {
    STAT_BUSY     = 3'd0,
    STAT_ACCEPT   = 3'd1,
    STAT_BADCHAR  = 3'd2,
    STAT_MISMATCH = 3'd3,
    STAT_SHORT    = 3'd4,
    STAT_EMPTY    = 3'd5,
    STAT_OVERFLOW = 3'd6
  } status_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_START = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_END   = 2'd2
  } action_e;

endpackage

// ===== rtl/ll1_table_parser.sv =====
// LL(1) table-driven recognizer, one result beat per input beat.
//
// s_axis: tuser = action (start / character / end), tdata = character byte.
// m_axis: tdata = {stack_depth, status}: the verdict and stack depth after
// the beat. cfg: one write per beat into the six rule registers; an index
// past the last rule is dropped. cfg_ready_o is always high.
//
// Start, end and unused actions go from IDLE straight to DONE. A character
// passes POP and READ for each symbol popped, each nonterminal expansion
// and the terminal that ends it, and PUSH for each symbol pushed: POP
// addresses the stack RAM, READ takes its registered read data, and PUSH
// is one RAM write.
// Only one beat is worked on at a time; the next is accepted once the
// result is in the output register, even while that result is stalled.
// A stalled m_axis holds its beat and the block waits with the next result.
//
// Reset clears the rule registers, leaves S as the only stack symbol and
// the verdict busy. No clearing pass: the bottom entry is marked as S by a
// flag until it is first written.
module ll1_table_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ll1tp_pkg::CHAR_W-1:0]        s_axis_tdata,   // [7:0] input_char
  input  logic [ll1tp_pkg::ACT_W-1:0]         s_axis_tuser,   // [1:0] action
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [2:0] status, [7:3] depth
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ll1tp_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [ll1tp_pkg::RULE_W-1:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_READ,
    ST_PUSH,
    ST_DONE
  } state_e;

  localparam int unsigned CNT_W  = ll1tp_pkg::CNT_W;
  localparam int unsigned ADDR_W = ll1tp_pkg::ADDR_W;
  localparam int unsigned BUD_W  = ll1tp_pkg::BUD_W;
  localparam int unsigned K_W    = ll1tp_pkg::K_W;
  localparam int unsigned LEN_W  = ll1tp_pkg::LEN_W;
  localparam int unsigned SYM_W  = ll1tp_pkg::SYM_W;
  localparam int unsigned RULE_W = ll1tp_pkg::RULE_W;

  localparam logic [ll1tp_pkg::IDX_W-1:0] IDX_LAST = ll1tp_pkg::IDX_W'(ll1tp_pkg::NUM_RULES);

  state_e                          state_q;
  logic [CNT_W-1:0]                count_q;
  ll1tp_pkg::status_e              verdict_q;
  logic                            bottom_s_q;   // entry 0 still reads as S
  logic                            col_q;        // terminal column being consumed
  logic [BUD_W-1:0]                budget_q;
  logic [RULE_W-1:0]               cur_rule_q;
  logic [LEN_W-1:0]                len_q;
  logic [K_W-1:0]                  k_q;
  logic [ADDR_W-1:0]               rd_addr_q;
  logic [RULE_W-1:0]               rules_q [ll1tp_pkg::NUM_RULES];

  logic                            out_valid_q;
  logic [ll1tp_pkg::STAT_W-1:0]    out_status_q;
  logic [ll1tp_pkg::DEPTH_W-1:0]   out_depth_q;

  // stack RAM
  ll1tp_pkg::sym_t                 stack_mem [ll1tp_pkg::STACK_DEPTH];
  ll1tp_pkg::sym_t                 rdata_q;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  ll1tp_pkg::sym_t                 mem_wdata;
  logic                            mem_re;
  logic [ADDR_W-1:0]               mem_raddr;

  logic                            in_fire;
  ll1tp_pkg::sym_t                 top_sym;
  logic                            top_is_nt;
  logic [RULE_W-1:0]               sel_rule;
  logic [LEN_W-1:0]                len_raw;
  logic [LEN_W-1:0]                len_clamp;
  logic                            push_ovf;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_depth_q, out_status_q};

  // symbol read back from the stack; bottom entry is S until overwritten
  assign top_sym   = (bottom_s_q && (rd_addr_q == '0)) ? ll1tp_pkg::SYM_S : rdata_q;
  assign top_is_nt = (top_sym == ll1tp_pkg::SYM_S) || (top_sym == ll1tp_pkg::SYM_A) ||
                     (top_sym == ll1tp_pkg::SYM_B);

  always_comb begin
    case (top_sym)
      ll1tp_pkg::SYM_S: sel_rule = col_q ? rules_q[1] : rules_q[0];
      ll1tp_pkg::SYM_A: sel_rule = col_q ? rules_q[3] : rules_q[2];
      ll1tp_pkg::SYM_B: sel_rule = col_q ? rules_q[5] : rules_q[4];
      default:          sel_rule = '0;
    endcase
  end

  assign len_raw   = sel_rule[LEN_W-1:0];
  assign len_clamp = (len_raw > LEN_W'(ll1tp_pkg::RULE_MAX_LEN)) ?
                     LEN_W'(ll1tp_pkg::RULE_MAX_LEN) : len_raw;
  assign push_ovf  = ({1'b0, count_q} + (CNT_W+1)'(len_clamp)) >
                     (CNT_W+1)'(ll1tp_pkg::STACK_DEPTH);

  // RAM port control
  assign mem_re    = (state_q == ST_POP) && (count_q != '0);
  assign mem_raddr = ADDR_W'(count_q - CNT_W'(1));
  assign mem_we    = (state_q == ST_PUSH);
  assign mem_waddr = count_q[ADDR_W-1:0];
  assign mem_wdata = cur_rule_q[SYM_W*(int'(k_q) + 1) +: SYM_W];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= stack_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= CNT_W'(1);
      verdict_q    <= ll1tp_pkg::STAT_BUSY;
      bottom_s_q   <= 1'b1;
      col_q        <= 1'b0;
      budget_q     <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < ll1tp_pkg::NUM_RULES; i++) begin
        rules_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && (cfg_index_i < IDX_LAST)) begin
        rules_q[cfg_index_i] <= cfg_data_i;
      end

      // ST_DONE reloads the output register itself
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (s_axis_tuser)
              ll1tp_pkg::ACT_START: begin
                count_q    <= CNT_W'(1);
                bottom_s_q <= 1'b1;
                verdict_q  <= ll1tp_pkg::STAT_BUSY;
                state_q    <= ST_DONE;
              end
              ll1tp_pkg::ACT_CHAR: begin
                if (verdict_q == ll1tp_pkg::STAT_BUSY && count_q != '0 &&
                    (s_axis_tdata == ll1tp_pkg::CHAR_ZERO ||
                     s_axis_tdata == ll1tp_pkg::CHAR_ONE)) begin
                  col_q    <= (s_axis_tdata == ll1tp_pkg::CHAR_ONE);
                  budget_q <= '0;
                  state_q  <= ST_POP;
                end else begin
                  state_q <= ST_DONE;
                  if (verdict_q == ll1tp_pkg::STAT_BUSY) begin
                    if (count_q == '0) begin
                      verdict_q <= ll1tp_pkg::STAT_EMPTY;
                    end else begin
                      verdict_q <= ll1tp_pkg::STAT_BADCHAR;
                    end
                  end
                end
              end
              ll1tp_pkg::ACT_END: begin
                state_q <= ST_DONE;
                if (verdict_q == ll1tp_pkg::STAT_BUSY) begin
                  verdict_q <= (count_q == '0) ? ll1tp_pkg::STAT_ACCEPT
                                               : ll1tp_pkg::STAT_SHORT;
                end
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end

        ST_POP: begin
          if (count_q == '0) begin
            verdict_q <= ll1tp_pkg::STAT_EMPTY;
            state_q   <= ST_DONE;
          end else begin
            count_q   <= count_q - CNT_W'(1);
            rd_addr_q <= mem_raddr;
            state_q   <= ST_READ;
          end
        end

        ST_READ: begin
          if (top_is_nt) begin
            if (budget_q >= BUD_W'(ll1tp_pkg::EXPAND_LIMIT) || push_ovf) begin
              verdict_q <= ll1tp_pkg::STAT_OVERFLOW;
              state_q   <= ST_DONE;
            end else begin
              budget_q   <= budget_q + BUD_W'(1);
              cur_rule_q <= sel_rule;
              len_q      <= len_clamp;
              k_q        <= '0;
              state_q    <= (len_clamp == '0) ? ST_POP : ST_PUSH;
            end
          end else begin
            if (top_sym != {{(SYM_W-1){1'b0}}, col_q}) begin
              verdict_q <= ll1tp_pkg::STAT_MISMATCH;
            end
            state_q <= ST_DONE;
          end
        end

        ST_PUSH: begin
          count_q <= count_q + CNT_W'(1);
          if (mem_waddr == '0) begin
            bottom_s_q <= 1'b0;
          end
          if (LEN_W'(k_q) + LEN_W'(1) == len_q) begin
            state_q <= ST_POP;
          end else begin
            k_q <= k_q + K_W'(1);
          end
        end

        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= verdict_q;
            out_depth_q  <= ll1tp_pkg::DEPTH_W'(count_q);
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ll1tp_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  // a push always has room, the overflow check ran before it
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (count_q < CNT_W'(ll1tp_pkg::STACK_DEPTH)))
    else $error("push into a full stack");

  // read data is only used the cycle after its address was issued
  a_read_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ($past(state_q) == ST_POP))
    else $error("stack read data used without a pop");

  // push index stays inside the rule being pushed
  a_push_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (LEN_W'(k_q) < len_q))
    else $error("push index past rule length");

  // a final verdict holds until the next start beat
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_q != ll1tp_pkg::STAT_BUSY &&
     !(in_fire && s_axis_tuser == ll1tp_pkg::ACT_START)) |=> $stable(verdict_q))
    else $error("final verdict changed without a start");

endmodule
